/* hw/rtl/mtwa_pkg.sv */
// Shared types and constants for the station address table with ageing.
`timescale 1ns / 1ps
`default_nettype none

package mtwa_pkg;

  localparam logic [1:0] MODE_HB    = 2'd0;
  localparam logic [1:0] MODE_SWEEP = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  localparam logic [2:0] EV_MATCHED   = 3'd0;
  localparam logic [2:0] EV_ADDED     = 3'd1;
  localparam logic [2:0] EV_FULL      = 3'd2;
  localparam logic [2:0] EV_UNCHANGED = 3'd3;
  localparam logic [2:0] EV_OFFLINE   = 3'd4;
  localparam logic [2:0] EV_EXPIRED   = 3'd5;
  localparam logic [2:0] EV_COUNT     = 3'd6;

  localparam logic REG_OFFLINE_IDX = 1'b0;
  localparam logic REG_REMOVE_IDX  = 1'b1;

  localparam logic [31:0] OFFLINE_LIMIT_RST = 32'd15000;
  localparam logic [31:0] REMOVE_LIMIT_RST  = 32'd60000;

  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_HB,
    OP_SWEEP,
    OP_COUNT
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] mac;
    logic [31:0] now;
    logic [31:0] stamp;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/mac_table_with_aging_unit.sv */
// Station address table with ageing: top level, register port and checks.
// Each command scans every slot through the table memory read port: a read, then an evaluate state.
// Heartbeat and count: one result, registered in the finish state after the last slot.
// Sweep: TABLE_ENTRIES results, one per slot; a stalled result register holds the scan.
// A 2-deep command queue lets input beats arrive while the scanner works.
// Reset clears slot valid bits, offline marks and queue at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mac_table_with_aging_unit #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_mode,
  input  wire logic [47:0]  in_mac,
  input  wire logic [31:0]  in_now_ms,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_event_res,
  output logic [3:0]        out_slot,
  output logic [47:0]       out_entry_mac,
  output logic [31:0]       out_age_ms,
  output logic [4:0]        out_active_count,
  output logic              out_last,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mtwa_pkg::*;

  logic [31:0] offline_r;
  logic [31:0] remove_r;
  logic        cfg_wr;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_OFFLINE_IDX: prdata = offline_r;
      REG_REMOVE_IDX:  prdata = remove_r;
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_r <= OFFLINE_LIMIT_RST;
      remove_r  <= REMOVE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_OFFLINE_IDX: offline_r <= pwdata;
        REG_REMOVE_IDX:  remove_r  <= pwdata;
        default:         offline_r <= offline_r;
      endcase
    end
  end

  mtwa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_mac    (in_mac),
    .in_now_ms (in_now_ms),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mtwa_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .offline_limit    (offline_r),
    .remove_limit     (remove_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_slot         (out_slot),
    .out_entry_mac    (out_entry_mac),
    .out_age_ms       (out_age_ms),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("queue or result register not empty after reset");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == EV_MATCHED || out_event_res == EV_ADDED ||
                   out_event_res == EV_FULL || out_event_res == EV_COUNT)) |-> out_last)
    else $error("single-beat result without last");

  a_full_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_FULL) |->
      (out_slot == 4'd0 && out_entry_mac == 48'd0 && out_age_ms == 32'd0))
    else $error("table full beat carries slot data");

  a_count_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_COUNT) |-> (out_active_count == 5'd0))
    else $error("active count on a non-count beat");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mtwa_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module mtwa_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_mode,
  input  wire logic [47:0]  in_mac,
  input  wire logic [31:0]  in_now_ms,
  output logic              cmd_valid,
  output mtwa_pkg::cmd_t    cmd,
  input  wire logic         cmd_pop
);
  import mtwa_pkg::*;

  cmd_t       q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;
  cmd_t       cls;

  always_comb begin
    keep      = 1'b1;
    cls.op    = OP_HB;
    cls.mac   = in_mac;
    cls.now   = in_now_ms;
    cls.stamp = (in_now_ms == 32'd0) ? 32'd1 : in_now_ms;
    case (in_mode)
      MODE_HB:    cls.op = OP_HB;
      MODE_SWEEP: cls.op = OP_SWEEP;
      MODE_COUNT: cls.op = OP_COUNT;
      default:    keep = 1'b0;
    endcase
  end

  assign in_stall  = (cnt_r == 2'(QDEPTH));
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mtwa_back.sv */
// Back end: slot scanner over the address table, result register.
`timescale 1ns / 1ps
`default_nettype none

module mtwa_back #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_valid,
  input  wire mtwa_pkg::cmd_t cmd,
  output logic              cmd_pop,
  input  wire logic [31:0]  offline_limit,
  input  wire logic [31:0]  remove_limit,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_event_res,
  output logic [3:0]        out_slot,
  output logic [47:0]       out_entry_mac,
  output logic [31:0]       out_age_ms,
  output logic [4:0]        out_active_count,
  output logic              out_last
);
  import mtwa_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

  function automatic logic [3:0] slot_of(input logic [IW-1:0] i);
    logic [IW+3:0] e;
    e = {4'b0, i};
    return e[3:0];
  endfunction

  function automatic logic [4:0] count_of(input logic [CW-1:0] c);
    logic [CW+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

  logic [47:0] mac_mem [TABLE_ENTRIES];
  logic [31:0] ls_mem  [TABLE_ENTRIES];

  state_t                   state_r, state_nxt;
  cmd_t                     cur_r;
  logic [IW-1:0]            idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] mark_r;
  logic                     found_r, free_r;
  logic [IW-1:0]            found_idx_r, free_idx_r;
  logic [CW-1:0]            cnt_r;
  logic [47:0]              rd_mac_r;
  logic [31:0]              rd_ls_r;
  logic                     out_valid_r;
  logic [2:0]               ev_r;
  logic [3:0]               slot_r;
  logic [47:0]              mac_r;
  logic [31:0]              age_r;
  logic [4:0]               acnt_r;
  logic                     last_r;

  logic          can_load, at_last;
  logic          rd_en, eval_en, sweep_load, fin_load, out_load, wr_en;
  logic          seen, hit, expire, go_off, young;
  logic [31:0]   age;
  logic [IW-1:0] wr_addr;
  logic [2:0]    res_ev;
  logic [3:0]    res_slot;
  logic [47:0]   res_mac;
  logic [31:0]   res_age;
  logic [4:0]    res_cnt;
  logic          res_last;

  assign can_load = !out_valid_r || !out_stall;
  assign at_last  = (idx_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EV;
      ST_EV: begin
        if (cur_r.op == OP_SWEEP) begin
          if (can_load) state_nxt = at_last ? ST_IDLE : ST_RD;
        end else begin
          state_nxt = at_last ? ST_FIN : ST_RD;
        end
      end
      ST_FIN:  if (can_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    eval_en    = 1'b0;
    sweep_load = 1'b0;
    fin_load   = 1'b0;
    case (state_r)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_RD:   rd_en = 1'b1;
      ST_EV: begin
        eval_en    = (cur_r.op != OP_SWEEP) || can_load;
        sweep_load = (cur_r.op == OP_SWEEP) && can_load;
      end
      ST_FIN:  fin_load = can_load;
      default: cmd_pop = 1'b0;
    endcase
  end

  assign out_load = sweep_load || fin_load;
  assign wr_en    = fin_load && (cur_r.op == OP_HB) && (found_r || free_r);
  assign wr_addr  = found_r ? found_idx_r : free_idx_r;

  always_comb begin
    seen   = valid_r[idx_r];
    age    = cur_r.now - rd_ls_r;
    hit    = seen && (rd_mac_r == cur_r.mac);
    expire = seen && (age >= remove_limit);
    go_off = seen && !expire && (age >= offline_limit) && !mark_r[idx_r];
    young  = seen && (age < offline_limit);
  end

  always_comb begin
    res_ev   = EV_UNCHANGED;
    res_slot = 4'd0;
    res_mac  = 48'd0;
    res_age  = 32'd0;
    res_cnt  = 5'd0;
    res_last = 1'b1;
    if (state_r == ST_EV) begin
      res_ev   = expire ? EV_EXPIRED : (go_off ? EV_OFFLINE : EV_UNCHANGED);
      res_slot = slot_of(idx_r);
      res_mac  = seen ? rd_mac_r : 48'd0;
      res_age  = seen ? age : 32'd0;
      res_last = at_last;
    end else begin
      case (cur_r.op)
        OP_HB: begin
          if (found_r) begin
            res_ev   = EV_MATCHED;
            res_slot = slot_of(found_idx_r);
            res_mac  = cur_r.mac;
          end else if (free_r) begin
            res_ev   = EV_ADDED;
            res_slot = slot_of(free_idx_r);
            res_mac  = cur_r.mac;
          end else begin
            res_ev = EV_FULL;
          end
        end
        OP_COUNT: begin
          res_ev  = EV_COUNT;
          res_cnt = count_of(cnt_r);
        end
        default: res_ev = EV_UNCHANGED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      mark_r      <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd_pop) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        free_r  <= 1'b0;
        cnt_r   <= '0;
      end else if (eval_en) begin
        if (!at_last) idx_r <= idx_r + IW'(1);
        if (cur_r.op == OP_HB) begin
          if (hit && !found_r) found_r <= 1'b1;
          if (!seen && !free_r) free_r <= 1'b1;
        end
        if ((cur_r.op == OP_COUNT) && young) cnt_r <= cnt_r + CW'(1);
      end
      if (sweep_load) begin
        if (expire) begin
          valid_r[idx_r] <= 1'b0;
          mark_r[idx_r]  <= 1'b0;
        end else if (go_off) begin
          mark_r[idx_r] <= 1'b1;
        end
      end
      if (wr_en && !found_r) valid_r[free_idx_r] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd;
    if (eval_en && (cur_r.op == OP_HB)) begin
      if (hit && !found_r) found_idx_r <= idx_r;
      if (!seen && !free_r) free_idx_r <= idx_r;
    end
    if (out_load) begin
      ev_r   <= res_ev;
      slot_r <= res_slot;
      mac_r  <= res_mac;
      age_r  <= res_age;
      acnt_r <= res_cnt;
      last_r <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mac_mem[wr_addr] <= cur_r.mac;
      ls_mem[wr_addr]  <= cur_r.stamp;
    end
    if (rd_en) begin
      rd_mac_r <= mac_mem[idx_r];
      rd_ls_r  <= ls_mem[idx_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = ev_r;
  assign out_slot         = slot_r;
  assign out_entry_mac    = mac_r;
  assign out_age_ms       = age_r;
  assign out_active_count = acnt_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the station address table with ageing.
`timescale 1ns / 1ps

module testbench;
  import mtwa_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int SETTLE_CYCLES = 140;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  slot;
    logic [47:0] mac;
    logic [31:0] age;
    logic [4:0]  cnt;
    logic        last;
  } table_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_HB;
  logic [47:0] in_mac = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [3:0]  out_slot;
  logic [47:0] out_entry_mac;
  logic [31:0] out_age_ms;
  logic [4:0]  out_active_count;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mac_table_with_aging_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode), .in_mac(in_mac),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res),
    .out_slot(out_slot), .out_entry_mac(out_entry_mac), .out_age_ms(out_age_ms),
    .out_active_count(out_active_count), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // table shadow
  logic [47:0] mac_held [TABLE_ENTRIES];
  logic [31:0] seen_ms [TABLE_ENTRIES];
  logic        marked [TABLE_ENTRIES];
  logic [31:0] offline_lim;
  logic [31:0] remove_lim;

  table_result_t pending_results[$];
  table_result_t oldest;
  logic [47:0]   mac_pool [POOL_SIZE];
  logic [31:0]   clock_ms;
  int            errors = 0;
  int            cycles = 0;
  int            burst_left = 0;
  int            stall_run = 0;
  int            stall_style = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall: calm, random and heavy stretches
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_run <= $urandom_range(20, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall <= (stall_run % 4 != 0);
      end
    endcase
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'(out_event_res), 64'd0);
      end else begin
        oldest = pending_results.pop_front();
        check_field("event_res", 64'(out_event_res), 64'(oldest.ev));
        check_field("slot", 64'(out_slot), 64'(oldest.slot));
        check_field("entry_mac", 64'(out_entry_mac), 64'(oldest.mac));
        check_field("age_ms", 64'(out_age_ms), 64'(oldest.age));
        check_field("active_count", 64'(out_active_count), 64'(oldest.cnt));
        check_field("last", 64'(out_last), 64'(oldest.last));
      end
    end
  end

  task automatic predict_table(input logic [1:0] mode, input logic [47:0] mac,
                               input logic [31:0] now);
    int i;
    int hit;
    int spare;
    int n;
    logic [31:0] age;
    table_result_t r;
    hit = -1;
    spare = -1;
    n = 0;
    case (mode)
      MODE_HB: begin
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (seen_ms[i] != 0) begin
            if (hit < 0 && mac_held[i] == mac) hit = i;
          end else if (spare < 0) begin
            spare = i;
          end
        end
        r = '0;
        r.last = 1'b1;
        if (hit >= 0) begin
          seen_ms[hit] = (now != 0) ? now : 32'd1;
          r.ev = EV_MATCHED;
          r.slot = hit[3:0];
          r.mac = mac;
        end else if (spare >= 0) begin
          mac_held[spare] = mac;
          seen_ms[spare] = (now != 0) ? now : 32'd1;
          r.ev = EV_ADDED;
          r.slot = spare[3:0];
          r.mac = mac;
        end else begin
          r.ev = EV_FULL;
        end
        pending_results.push_back(r);
      end
      MODE_SWEEP: begin
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          r = '0;
          r.ev = EV_UNCHANGED;
          r.slot = i[3:0];
          r.mac = mac_held[i];
          r.last = (i == TABLE_ENTRIES - 1);
          if (seen_ms[i] != 0) begin
            age = now - seen_ms[i];
            r.age = age;
            if (age >= remove_lim) begin
              r.ev = EV_EXPIRED;
              mac_held[i] = '0;
              seen_ms[i] = '0;
              marked[i] = 1'b0;
            end else if (age >= offline_lim && !marked[i]) begin
              r.ev = EV_OFFLINE;
              marked[i] = 1'b1;
            end
          end
          pending_results.push_back(r);
        end
      end
      MODE_COUNT: begin
        for (i = 0; i < TABLE_ENTRIES; i++)
          if (seen_ms[i] != 0 && (now - seen_ms[i]) < offline_lim) n++;
        r = '0;
        r.ev = EV_COUNT;
        r.cnt = n[4:0];
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // one input beat; bursts end in a gap or, now and then, a full drain
  task automatic send_beat(input logic [1:0] mode, input logic [47:0] mac,
                           input logic [31:0] now);
    in_mode <= mode;
    in_mac <= mac;
    in_now_ms <= now;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_table(mode, mac, now);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 24) == 0) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic settle_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_OFFLINE_IDX) offline_lim = value;
    else remove_lim = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("limit readback", 64'(prdata), 64'(value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_heartbeat_ageing();
    send_beat(MODE_HB, 48'h0, 32'd0);
    send_beat(MODE_HB, 48'h0, 32'd5);
    send_beat(MODE_HB, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(MODE_COUNT, rand_mac(), 32'd100);
    send_beat(MODE_SWEEP, rand_mac(), 32'd20000);
    send_beat(MODE_SWEEP, 48'h0, 32'd20000);
    send_beat(MODE_HB, 48'h0, 32'd20001);
    send_beat(MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(MODE_SWEEP, 48'h0, 32'd80001);
    settle_table();
  endtask

  task automatic test_table_full();
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++)
      send_beat(MODE_HB, {16'hA5C3, i[7:0], 8'($urandom_range(0, 255)), 16'h0},
                32'd1000 + i);
    send_beat(MODE_HB, rand_mac(), 32'd2000);
    send_beat(MODE_COUNT, 48'h0, 32'd2000);
    send_beat(MODE_SWEEP, 48'h0, 32'd70000);
    settle_table();
  endtask

  task automatic test_random_traffic(input logic [31:0] off_l, input logic [31:0] rem_l,
                                     input int n_items, input int step_max);
    int done;
    int pick;
    logic [1:0] mode;
    logic [47:0] mac;
    logic [31:0] now;
    done = 0;
    settle_table();
    write_limit(REG_OFFLINE_IDX, off_l);
    write_limit(REG_REMOVE_IDX, rem_l);
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) mode = MODE_HB;
      else if (pick < 75) mode = MODE_SWEEP;
      else if (pick < 95) mode = MODE_COUNT;
      else mode = MODE_UNUSED;
      if ($urandom_range(0, 6) == 0) mac = rand_mac();
      else mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) begin
        now = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now = clock_ms;
      end
      send_beat(mode, mac, now);
      if (mode != MODE_UNUSED) done++;
    end
    settle_table();
  endtask

  initial begin
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      mac_held[i] = '0;
      seen_ms[i] = '0;
      marked[i] = 1'b0;
    end
    offline_lim = OFFLINE_LIMIT_RST;
    remove_lim = REMOVE_LIMIT_RST;
    clock_ms = 32'd90000;
    mac_pool[0] = 48'h0;
    mac_pool[1] = 48'hFFFF_FFFF_FFFF;
    for (i = 2; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_heartbeat_ageing();
    test_table_full();
    test_random_traffic(OFFLINE_LIMIT_RST, REMOVE_LIMIT_RST, 55, 4000);
    test_random_traffic(32'd40, 32'd120, 55, 30);
    test_random_traffic(32'd300, 32'd100, 35, 60);
    test_random_traffic(32'd0, 32'd0, 15, 20);
    test_random_traffic(32'd1, 32'hFFFF_FFFF, 15, 5);
    test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20, 32'h7FFF_FFFF);
    settle_table();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
